/* rtl/core/bloom_filter_three_hash_query_unit_assert.svh */
// ----------------------------------------------------------------------------
// Bloom filter query unit assertion macros
// Concurrent assertion wrappers shared by the RTL of the query unit.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_THREE_HASH_QUERY_UNIT_ASSERT_SVH
`define BLOOM_FILTER_THREE_HASH_QUERY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bfq_pkg.sv */
// ----------------------------------------------------------------------------
// Bloom filter query package
// Hash constants, hash helper functions and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bfq_pkg;

    localparam logic [31:0] MUL_GOLDEN = 32'd2654435761;
    localparam logic [31:0] MUL_FINAL  = 32'h045D_9F3B;

    // Transaction kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Width of the value that gets reduced to a table address
    localparam int unsigned XW = 16;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b0_0000_0001,
        ST_IDLE  = 9'b0_0000_0010,
        ST_MUL1  = 9'b0_0000_0100,
        ST_MUL2  = 9'b0_0000_1000,
        ST_MUL3  = 9'b0_0001_0000,
        ST_MOD   = 9'b0_0010_0000,
        ST_REM   = 9'b0_0100_0000,
        ST_MEM   = 9'b0_1000_0000,
        ST_CHK   = 9'b1_0000_0000
    } t_state;

    // 13/17/5 xorshift
    function automatic logic [31:0] bfq_xorshift(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        a = v ^ (v >> 13);
        b = a ^ (a << 17);
        return b ^ (b >> 5);
    endfunction

    // x ^ (x >> 16), the fold step of the finalizer
    function automatic logic [31:0] bfq_fold16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bloom_filter_three_hash_query_unit.sv */
// ----------------------------------------------------------------------------
// Bloom filter three-hash query unit
// Blocked Bloom filter over a table of TABLE_WORDS 32-bit words held in one
// synchronous RAM. A write transaction (kind 0) stores word_value at
// word_index mod TABLE_WORDS and returns nothing. A query transaction
// (kind 1) hashes code_point three ways: a golden-ratio multiply picks the
// table word, and the low five bits of an xorshift hash, a finalizer hash
// and their sum pick three bits that must all be set for maybe_present = 1.
// One transaction is in flight at a time: busy is high from the cycle after
// start is taken until the unit can take the next one. A 32x32 multiplier
// is shared by the golden-ratio and finalizer hashes in ST_MUL1, ST_MUL2
// and ST_MUL3; a query then does one RAM access (ST_MEM) and one compare
// (ST_CHK), while a write skips the multiplies and only does ST_MEM. When
// TABLE_WORDS is not a power of two the address is reduced by a reciprocal
// multiply (quotient, ST_MOD) and a multiply-subtract (remainder, ST_REM),
// added to every transaction. The result strobe o_result_valid is high
// for exactly one cycle, the cycle after the compare; the receiver cannot
// stall it. After reset the RAM is swept to zero, one word per cycle, and
// busy stays high until the whole table is clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bloom_filter_three_hash_query_unit_assert.svh"

module bloom_filter_three_hash_query_unit
    import bfq_pkg::*;
#(
    parameter int unsigned TABLE_WORDS = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [11:0] i_word_index,
    input  wire logic [31:0] i_word_value,
    input  wire logic [31:0] i_code_point,
    output logic             o_result_valid,
    output logic             o_maybe_present
);

    localparam int unsigned AW      = $clog2(TABLE_WORDS);
    localparam bit          IS_POW2 = (TABLE_WORDS & (TABLE_WORDS - 1)) == 0;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_WORDS - 1);
    // ceil(2^32 / TABLE_WORDS): exact floor division for any 16-bit x
    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + 64'(TABLE_WORDS) - 64'd1) / 64'(TABLE_WORDS);
    localparam logic [32:0] RECIP = 33'(RECIP_L);
    localparam logic [16:0] T17   = 17'(TABLE_WORDS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic            r_kind;
    logic [31:0]     r_val;       // word to store
    logic [31:0]     r_code;      // value to hash
    logic [XW-1:0]   r_x;         // unreduced address (h1 or word_index)
    logic [XW-1:0]   r_q;         // x / TABLE_WORDS
    logic [AW-1:0]   r_rem;       // x mod TABLE_WORDS
    logic [31:0]     r_prod;      // finalizer intermediate
    logic [4:0]      r_h2;        // low bits of xorshift hash
    logic            r_result_valid, n_result_valid;
    logic            r_maybe, n_maybe;

    // ------------------------------------------------------------------
    // Filter RAM, one port, registered read
    // ------------------------------------------------------------------
    logic [31:0]     mem [TABLE_WORDS];
    logic [31:0]     r_rdata;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic            mem_re;
    logic [31:0]     mem_wdata;

    // ------------------------------------------------------------------
    // Shared multiplier and hash helpers
    // ------------------------------------------------------------------
    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic [31:0]     mul_prod;
    logic [31:0]     h2_full;
    logic [4:0]      h3_lo;
    logic [4:0]      sum_lo;
    logic [31:0]     mask;
    logic [48:0]     q_prod;
    logic [XW-1:0]   qt_lo;
    logic [XW-1:0]   rem_full;
    logic            accept;
    logic [AW-1:0]   q_addr;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        case (r_state)
            ST_MUL1: begin
                mul_a = r_code;
                mul_b = MUL_GOLDEN;
            end
            ST_MUL2: begin
                mul_a = bfq_fold16(r_code);
                mul_b = MUL_FINAL;
            end
            default: begin
                mul_a = bfq_fold16(r_prod);
                mul_b = MUL_FINAL;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;   // low 32 bits only
    assign h2_full  = bfq_xorshift(r_code);

    // Last fold of the finalizer, low five bits only
    assign h3_lo  = r_prod[4:0] ^ r_prod[20:16];
    assign sum_lo = r_h2 + h3_lo;
    assign mask   = (32'd1 << r_h2) | (32'd1 << h3_lo) | (32'd1 << sum_lo);

    // Address reduction: quotient by reciprocal, then x - q * TABLE_WORDS
    assign q_prod   = {33'd0, r_x} * {16'd0, RECIP};
    assign qt_lo    = XW'(r_q * T17);  // q * T never exceeds x
    assign rem_full = r_x - qt_lo;

    assign q_addr = IS_POW2 ? r_x[AW-1:0] : r_rem;

    always_comb begin
        mem_addr  = q_addr;
        mem_wdata = r_val;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (r_state == ST_CLEAR) begin
            mem_addr  = r_clr_addr;
            mem_wdata = 32'd0;
            mem_we    = 1'b1;
        end else if (r_state == ST_MEM) begin
            mem_we = (r_kind == KIND_WRITE);
            mem_re = (r_kind == KIND_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb begin
        n_state        = r_state;
        n_result_valid = 1'b0;
        n_maybe        = r_maybe;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_QUERY) begin
                        n_state = ST_MUL1;
                    end else begin
                        n_state = IS_POW2 ? ST_MEM : ST_MOD;
                    end
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = IS_POW2 ? ST_MEM : ST_MOD;
            ST_MOD:  n_state = ST_REM;
            ST_REM:  n_state = ST_MEM;
            ST_MEM: begin
                n_state = (r_kind == KIND_QUERY) ? ST_CHK : ST_IDLE;
            end
            ST_CHK: begin
                n_state        = ST_IDLE;
                n_result_valid = 1'b1;
                n_maybe        = ((r_rdata & mask) == mask);
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_maybe <= n_maybe;
        if (accept) begin
            r_kind <= i_kind;
            r_val  <= i_word_value;
            r_code <= i_code_point;
            r_x    <= XW'(i_word_index);
        end
        case (r_state)
            ST_MUL1: begin
                r_x  <= mul_prod[31:16];
                r_h2 <= h2_full[4:0];
            end
            ST_MUL2, ST_MUL3: begin
                r_prod <= mul_prod;
            end
            ST_MOD: begin
                r_q <= q_prod[32 +: XW];
            end
            ST_REM: begin
                r_rem <= rem_full[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid  = r_result_valid;
    assign o_maybe_present = r_maybe;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BFQ_ASSERT_NEXT(a_chk_gives_result, i_clk, i_rst_n, r_state == ST_CHK, o_result_valid, "no strobe after compare")
    `BFQ_ASSERT_NOW(a_result_from_chk, i_clk, i_rst_n, o_result_valid, $past(r_state) == ST_CHK, "strobe without compare")
    `BFQ_ASSERT_NEXT(a_clear_runs, i_clk, i_rst_n, r_state == ST_CLEAR && r_clr_addr != LAST_ADDR, r_state == ST_CLEAR, "clear left early")
    `BFQ_ASSERT_NOW(a_rem_bound, i_clk, i_rst_n, r_state == ST_REM, 17'(rem_full) < T17, "remainder out of range")

endmodule

`default_nettype wire

/* verif/bloom_filter_tracker_pkg.sv */
// ----------------------------------------------------------------------------
// Bloom filter tracker
// Shadow copy of the filter table and the queue of pending query answers,
// used by the query unit testbench to predict and check maybe_present.
// ----------------------------------------------------------------------------
package bloom_filter_tracker_pkg;

    import bfq_pkg::KIND_WRITE;

    class bloom_filter_tracker;

        localparam int unsigned WORDS = 4096;
        localparam bit [31:0] GOLDEN = 32'd2654435761;
        localparam bit [31:0] FINAL_MUL = 32'h045D_9F3B;

        bit [31:0] filter_words [WORDS];
        bit pending_answers [$];
        int unsigned fail_count;

        function new();
            foreach (filter_words[i]) filter_words[i] = '0;
            fail_count = 0;
        endfunction

        // table word picked by a code point
        function bit [11:0] word_addr(bit [31:0] v);
            bit [31:0] prod;
            prod = v * GOLDEN;
            return 12'((prod >> 16) % WORDS);
        endfunction

        function bit [31:0] xorshift_hash(bit [31:0] v);
            bit [31:0] a;
            bit [31:0] b;
            a = v ^ (v >> 13);
            b = a ^ (a << 17);
            return b ^ (b >> 5);
        endfunction

        function bit [31:0] finalizer_hash(bit [31:0] v);
            bit [31:0] x;
            x = (v ^ (v >> 16)) * FINAL_MUL;
            x = (x ^ (x >> 16)) * FINAL_MUL;
            return x ^ (x >> 16);
        endfunction

        // three probe bits; fewer than three set when positions coincide
        function bit [31:0] probe_mask(bit [31:0] v);
            bit [31:0] h2;
            bit [31:0] h3;
            bit [31:0] hs;
            h2 = xorshift_hash(v);
            h3 = finalizer_hash(v);
            hs = h2 + h3;
            return (32'd1 << h2[4:0]) | (32'd1 << h3[4:0]) | (32'd1 << hs[4:0]);
        endfunction

        function void note_item(logic kind, bit [11:0] idx, bit [31:0] val, bit [31:0] cp);
            bit [31:0] m;
            if (kind == KIND_WRITE) begin
                filter_words[idx % WORDS] = val;
            end else begin
                m = probe_mask(cp);
                pending_answers.push_back((filter_words[word_addr(cp)] & m) == m);
            end
        endfunction

        function void check_result(bit got);
            bit want;
            if (pending_answers.size() == 0) begin
                $error("maybe_present: result strobe with no query pending, got %0b", got);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (want != got) begin
                    $error("maybe_present: expected %0b, actual %0b", want, got);
                    fail_count++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_answers.size();
        endfunction

    endclass

endpackage

/* verif/bloom_filter_three_hash_query_unit_test.sv */
// ----------------------------------------------------------------------------
// Bloom filter three-hash query unit testbench
// Drives directed and random-burst write and query transactions through the
// start/busy handshake, predicts every maybe_present answer from a shadow
// table and checks each result strobe against the oldest pending answer.
// ----------------------------------------------------------------------------
module bloom_filter_three_hash_query_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bfq_pkg::KIND_WRITE;
    import bfq_pkg::KIND_QUERY;
    import bloom_filter_tracker_pkg::*;

    // Watchdog limit, well above the clear sweep after reset.
    localparam int unsigned QUIET_LIMIT  = 20000;
    // Idle time after the last pending answer has been checked.
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = KIND_WRITE;
    logic [11:0] i_word_index = '0;
    logic [31:0] i_word_value = '0;
    logic [31:0] i_code_point = '0;
    logic        o_result_valid;
    logic        o_maybe_present;

    bloom_filter_tracker tracker = new();

    int unsigned quiet_cycles = 0;
    int unsigned items_sent = 0;
    bit [31:0]   recent_probes [$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bloom_filter_three_hash_query_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_word_index    (i_word_index),
        .i_word_value    (i_word_value),
        .i_code_point    (i_code_point),
        .o_result_valid  (o_result_valid),
        .o_maybe_present (o_maybe_present)
    );

    // ------------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Inputs move only on the
    // falling edge, and the block's outputs still show their pre-edge values.
    // The result check runs before noting a new transaction so a query taken
    // on the strobe cycle never lines up against its own answer.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit active;
        active = 1'b0;
        if (i_rst_n) begin
            if (o_result_valid) begin
                tracker.check_result(o_maybe_present);
                active = 1'b1;
            end
            if (start && !busy) begin
                tracker.note_item(i_kind, i_word_index, i_word_value, i_code_point);
                active = 1'b1;
            end
        end
        quiet_cycles <= active ? 0 : quiet_cycles + 1;
    end

    // Watchdog: nothing taken and nothing returned for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Called at a falling edge, return at a falling edge.
    // ------------------------------------------------------------------------

    // Present one transaction and hold it until the block takes it.
    task automatic send_item(logic kind, bit [11:0] idx, bit [31:0] val, bit [31:0] cp);
        start        <= 1'b1;
        i_kind       <= kind;
        i_word_index <= idx;
        i_word_value <= val;
        i_code_point <= cp;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Sender gap; unused fields carry junk meanwhile.
    task automatic hold_off(int unsigned n);
        start <= 1'b0;
        repeat (n) begin
            i_kind       <= 1'($urandom_range(0, 1));
            i_word_index <= 12'($urandom);
            i_word_value <= $urandom;
            i_code_point <= $urandom;
            @(negedge i_clk);
        end
    endtask

    // Well-formed probe: load the word a code point lands on, then query it.
    // One time in three a needed bit is knocked out so the answer is a miss.
    task automatic probe_pair(bit [31:0] v);
        bit [31:0] m;
        bit [31:0] w;
        m = tracker.probe_mask(v);
        w = ($urandom & $urandom) | m;
        if ($urandom_range(0, 2) == 0) w &= ~(m & (~m + 32'd1));
        send_item(KIND_WRITE, tracker.word_addr(v), w, $urandom);
        send_item(KIND_QUERY, 12'($urandom), $urandom, v);
        recent_probes.push_back(v);
        if (recent_probes.size() > 16) void'(recent_probes.pop_front());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [31:0]   v_top;
        bit [31:0]   v_tie;
        bit [31:0]   m;
        int unsigned burst;
        int unsigned pick;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // code point whose hash lands on the last table word
        v_top = 0;
        while (tracker.word_addr(v_top) != 12'hFFF) v_top++;
        // code point whose probe bits coincide
        v_tie = 0;
        while ($countones(tracker.probe_mask(v_tie)) == 3) v_tie++;

        // Directed: empty table, field extremes, both ends of the table.
        send_item(KIND_QUERY, 12'h000, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_QUERY, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 12'h000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(KIND_QUERY, 12'hFFF, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_QUERY, 12'h000, 32'h0000_0000, v_top);
        send_item(KIND_WRITE, 12'h000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(KIND_WRITE, tracker.word_addr(32'hFFFF_FFFF), 32'hFFFF_FFFF, 32'h0);
        send_item(KIND_QUERY, 12'h000, 32'h0000_0000, 32'hFFFF_FFFF);
        hold_off(3);
        // Coinciding probe bits: exact mask hits, one bit short and the complement miss.
        m = tracker.probe_mask(v_tie);
        send_item(KIND_WRITE, tracker.word_addr(v_tie), m, 32'h0);
        send_item(KIND_QUERY, 12'h000, 32'h0, v_tie);
        send_item(KIND_WRITE, tracker.word_addr(v_tie), m & ~(m & (~m + 32'd1)), 32'h0);
        send_item(KIND_QUERY, 12'h000, 32'h0, v_tie);
        send_item(KIND_WRITE, tracker.word_addr(v_tie), ~m, 32'h0);
        send_item(KIND_QUERY, 12'h000, 32'h0, v_tie);
        hold_off(2);

        // Random bursts: mostly write-then-query probes, plus stray writes and
        // queries, some of them revisiting earlier probes after overwrites.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(1, 8);
            repeat (burst) begin
                if (items_sent >= RANDOM_ITEMS) break;
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    probe_pair($urandom);
                end else if (pick < 7) begin
                    send_item(KIND_WRITE, 12'($urandom), $urandom, $urandom);
                end else if (pick < 8 && recent_probes.size() != 0) begin
                    send_item(KIND_QUERY, 12'($urandom), $urandom,
                              recent_probes[$urandom_range(0, recent_probes.size() - 1)]);
                end else begin
                    send_item(KIND_QUERY, 12'($urandom), $urandom, $urandom);
                end
            end
            hold_off($urandom_range(1, 8));
        end

        start <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
